>>> design/dlcnt_pkg.sv
`timescale 1ns / 1ps

package dlcnt_pkg;

    localparam int CountWidth   = 8;
    localparam int LockoutWidth = 16;
    localparam int TimeWidth    = 32;
    localparam int NumButtons   = 4;
    localparam int AddrWidth    = 4;
    localparam int DataWidth    = 32;
    localparam int OutTdataWidth = 24;

    typedef logic [CountWidth-1:0]   count_t;
    typedef logic [LockoutWidth-1:0] lockout_t;
    typedef logic [TimeWidth-1:0]    stamp_t;

    typedef enum logic [1:0] {
        CMD_GATE_A = 2'd0,
        CMD_GATE_B = 2'd1,
        CMD_MODE   = 2'd2,
        CMD_RESET  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_COUNT_MAX     = 2'd0,
        REG_COUNT_PRESET  = 2'd1,
        REG_LOCKOUT_TICKS = 2'd2,
        REG_NONE          = 2'd3
    } reg_idx_t;

    localparam count_t   CountMaxReset   = count_t'(100);
    localparam count_t   CountResetValue = count_t'(50);
    localparam lockout_t LockoutReset    = lockout_t'(50);

    typedef struct packed {
        count_t   count_max;
        count_t   count_preset;
        lockout_t lockout_ticks;
    } cfg_t;

    function automatic count_t step_count(input count_t value, input logic up,
                                          input count_t limit);
        count_t res;
        res = value;
        if (up) begin
            if (value < limit) begin
                res = value + count_t'(1);
            end
        end else begin
            if (value != count_t'(0)) begin
                res = value - count_t'(1);
            end
        end
        return res;
    endfunction

endpackage

>>> design/dlcnt_regs.sv
`timescale 1ns / 1ps

module dlcnt_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dlcnt_pkg::AddrWidth-1:0]   paddr,
    input  logic [dlcnt_pkg::DataWidth-1:0]   pwdata,
    output logic [dlcnt_pkg::DataWidth-1:0]   prdata,
    output logic                              pready,
    output dlcnt_pkg::cfg_t                   cfg
);

    dlcnt_pkg::cfg_t     cfg_reg;
    dlcnt_pkg::reg_idx_t idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = dlcnt_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.count_max     <= dlcnt_pkg::CountMaxReset;
            cfg_reg.count_preset  <= dlcnt_pkg::CountResetValue;
            cfg_reg.lockout_ticks <= dlcnt_pkg::LockoutReset;
        end else if (wr_en) begin
            case (idx)
                dlcnt_pkg::REG_COUNT_MAX: begin
                    cfg_reg.count_max <= pwdata[dlcnt_pkg::CountWidth-1:0];
                end
                dlcnt_pkg::REG_COUNT_PRESET: begin
                    cfg_reg.count_preset <= pwdata[dlcnt_pkg::CountWidth-1:0];
                end
                dlcnt_pkg::REG_LOCKOUT_TICKS: begin
                    cfg_reg.lockout_ticks <= pwdata[dlcnt_pkg::LockoutWidth-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            dlcnt_pkg::REG_COUNT_MAX:
                prdata = dlcnt_pkg::DataWidth'(cfg_reg.count_max);
            dlcnt_pkg::REG_COUNT_PRESET:
                prdata = dlcnt_pkg::DataWidth'(cfg_reg.count_preset);
            dlcnt_pkg::REG_LOCKOUT_TICKS:
                prdata = dlcnt_pkg::DataWidth'(cfg_reg.lockout_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> design/dual_lockout_up_down_counter_unit.sv
`timescale 1ns / 1ps
// Channel | Ports                  | Word
// input   | s_tvalid/tready/tdata  | tdata: now_ms[31:0]; tuser: command[1:0]
// result  | m_tvalid/tready/tdata  | tdata: count_a_out, count_b_out, direction_up, changed
// config  | APB psel..pready       | 0x0 count_max, 0x4 count_preset, 0x8 lockout_ticks
// One word per cycle unless m_tready stalls; words go via input reg to result reg.
// The input register and the result register form a two-stage pipe with a shared stall.
// Counters, direction and lockout timestamps update in the compute stage as it advances.
// Reset (synchronous, aresetn low) clears timestamps, loads counters to 50, direction up.

module dual_lockout_up_down_counter_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [dlcnt_pkg::TimeWidth-1:0]       s_tdata,  // now_ms[31:0]
    input  logic [1:0]                            s_tuser,  // command[1:0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // count_a_out[7:0], count_b_out[15:8], direction_up[16], changed[17], zero[23:18]
    output logic [dlcnt_pkg::OutTdataWidth-1:0]   m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dlcnt_pkg::AddrWidth-1:0]       paddr,
    input  logic [dlcnt_pkg::DataWidth-1:0]       pwdata,
    output logic [dlcnt_pkg::DataWidth-1:0]       prdata,
    output logic                                  pready
);

    dlcnt_pkg::cfg_t   cfg;

    logic              in_valid_reg;
    dlcnt_pkg::cmd_t   in_cmd_reg;
    dlcnt_pkg::stamp_t in_now_reg;

    dlcnt_pkg::stamp_t last_time_reg [dlcnt_pkg::NumButtons];
    dlcnt_pkg::count_t count_a_reg;
    dlcnt_pkg::count_t count_b_reg;
    logic              dir_reg;

    logic              out_valid_reg;
    dlcnt_pkg::count_t out_a_reg;
    dlcnt_pkg::count_t out_b_reg;
    logic              out_dir_reg;
    logic              out_changed_reg;

    logic              advance;
    logic              fire;
    dlcnt_pkg::stamp_t elapsed;
    logic              accepted;
    dlcnt_pkg::count_t count_a_next;
    dlcnt_pkg::count_t count_b_next;
    logic              dir_next;

    dlcnt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign elapsed  = in_now_reg - last_time_reg[in_cmd_reg];
    assign accepted = elapsed >= dlcnt_pkg::stamp_t'(cfg.lockout_ticks);

    always_comb begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        dir_next     = dir_reg;
        if (accepted) begin
            case (in_cmd_reg)
                dlcnt_pkg::CMD_GATE_A: begin
                    count_a_next = dlcnt_pkg::step_count(count_a_reg, dir_reg,
                                                         cfg.count_max);
                end
                dlcnt_pkg::CMD_GATE_B: begin
                    count_b_next = dlcnt_pkg::step_count(count_b_reg, dir_reg,
                                                         cfg.count_max);
                end
                dlcnt_pkg::CMD_MODE: begin
                    dir_next = !dir_reg;
                end
                dlcnt_pkg::CMD_RESET: begin
                    count_a_next = cfg.count_preset;
                    count_b_next = cfg.count_preset;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= dlcnt_pkg::cmd_t'(s_tuser);
            in_now_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dlcnt_pkg::NumButtons; i++) begin
                last_time_reg[i] <= '0;
            end
            count_a_reg <= dlcnt_pkg::CountResetValue;
            count_b_reg <= dlcnt_pkg::CountResetValue;
            dir_reg     <= 1'b1;
        end else if (fire) begin
            if (accepted) begin
                last_time_reg[in_cmd_reg] <= in_now_reg;
            end
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            dir_reg     <= dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_a_reg       <= count_a_next;
            out_b_reg       <= count_b_next;
            out_dir_reg     <= dir_next;
            out_changed_reg <= accepted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_changed_reg, out_dir_reg, out_b_reg, out_a_reg};

endmodule
